// ===== rtl/c8_pkg.sv =====
// shared types, codes and constants of the chip-8 core
package c8_pkg;

	localparam int unsigned MEM_BYTES  = 4096;
	localparam int unsigned MEM_AW     = $clog2(MEM_BYTES);
	localparam int unsigned FB_BYTES   = 256;
	localparam int unsigned FB_AW      = $clog2(FB_BYTES);
	localparam int unsigned NUM_V      = 16;
	localparam int unsigned V_AW       = $clog2(NUM_V);
	localparam int unsigned FONT_BYTES = 80;
	localparam int unsigned FONT_AW    = $clog2(FONT_BYTES);

	localparam logic [11:0] PC_START   = 12'h200;
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;

	localparam logic [15:0] OPC_CLS    = 16'h00E0;
	localparam logic [15:0] OPC_RET    = 16'h00EE;
	localparam logic [7:0]  KK_SKP     = 8'h9E;
	localparam logic [7:0]  KK_SKNP    = 8'hA1;
	localparam logic [7:0]  KK_LD_DT   = 8'h07;
	localparam logic [7:0]  KK_WAIT    = 8'h0A;
	localparam logic [7:0]  KK_SET_DT  = 8'h15;
	localparam logic [7:0]  KK_SET_ST  = 8'h18;
	localparam logic [7:0]  KK_ADD_I   = 8'h1E;
	localparam logic [7:0]  KK_FONT    = 8'h29;
	localparam logic [7:0]  KK_BCD     = 8'h33;
	localparam logic [7:0]  KK_STORE   = 8'h55;
	localparam logic [7:0]  KK_LOAD    = 8'h65;

	localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [1:0] {
		CMD_EXEC      = 2'd0,
		CMD_TICK      = 2'd1,
		CMD_MEM_WRITE = 2'd2,
		CMD_FB_READ   = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_ACCEPT,
		OP_TICK,
		OP_MEM_WRITE,
		OP_FB_READ,
		OP_FB_CAPTURE,
		OP_FETCH_HI,
		OP_FETCH_LO,
		OP_READ_X,
		OP_READ_Y,
		OP_CAP_Y,
		OP_EXEC,
		OP_FLAG,
		OP_CLS,
		OP_BCD,
		OP_ST_RD,
		OP_ST_WR,
		OP_LD_RD,
		OP_LD_WR,
		OP_SPR_MEM,
		OP_SPR_RD1,
		OP_SPR_WR1,
		OP_SPR_RD2,
		OP_SPR_WR2,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [2:0] {
		SEQ_DONE,
		SEQ_FLAG,
		SEQ_CLS,
		SEQ_BCD,
		SEQ_STORE,
		SEQ_LOAD,
		SEQ_SPRITE
	} seq_t;

	typedef struct packed {
		logic init_last;
		cmd_t cmd;
		seq_t seq;
		logic cnt_last;
	} dp_stat_t;

	function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] addr);
		logic [FONT_AW-1:0] idx;
		idx = addr[FONT_AW-1:0];
		return (addr < MEM_AW'(FONT_BYTES)) ? FONT_ROM[idx] : 8'h00;
	endfunction

endpackage

// ===== rtl/c8_in_if.sv =====
// input item channel of the chip-8 core
interface c8_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic [15:0] key_mask;

	modport source (output valid, command, address, write_data, key_mask, input ready);
	modport sink (input valid, command, address, write_data, key_mask, output ready);
endinterface

// ===== rtl/c8_out_if.sv =====
// result item channel of the chip-8 core
interface c8_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        draw_changed;
	logic        waiting_key;
	logic        sound_on;
	logic        unknown_op;
	logic [11:0] program_counter;

	modport source (output valid, read_data, draw_changed, waiting_key, sound_on, unknown_op,
		program_counter, input ready);
	modport sink (input valid, read_data, draw_changed, waiting_key, sound_on, unknown_op,
		program_counter, output ready);
endinterface

// ===== rtl/c8_ram.sv =====
// generic single-port ram with registered read
module c8_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/c8_dpath.sv =====
// datapath of the chip-8 core: memories, registers, alu and sprite logic
module c8_dpath #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  c8_pkg::dp_op_t   op,
	input  logic [1:0]       in_command,
	input  logic [11:0]      in_address,
	input  logic [7:0]       in_write_data,
	input  logic [15:0]      in_key_mask,
	output c8_pkg::dp_stat_t stat,
	output logic [7:0]       read_data,
	output logic             draw_changed,
	output logic             waiting_key,
	output logic             sound_on,
	output logic             unknown_op,
	output logic [11:0]      program_counter
);
	localparam int unsigned SP_W = $clog2(STACK_DEPTH);

	c8_pkg::cmd_t cmd_q;
	logic [11:0]  addr_q;
	logic [7:0]   wdata_q;
	logic [15:0]  keys_q;
	logic [15:0]  op_q;
	logic [7:0]   vx_q;
	logic [7:0]   vy_q;
	logic [15:0]  spr_q;
	logic [11:0]  bcd_q;
	logic         flag_q;
	logic [7:0]   rd_q;
	logic         draw_q;
	logic         wait_q;
	logic         unk_q;
	logic [7:0]   cnt_q;

	logic [11:0]  pc_q;
	logic [11:0]  i_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]   dt_q;
	logic [7:0]   st_q;
	logic [15:0]  lfsr_q;
	logic [11:0]  stack_q [STACK_DEPTH];
	logic [11:0]  clr_q;

	logic [3:0]   f_x, f_y, f_n;
	logic [7:0]   f_kk;
	logic [11:0]  f_nnn;

	logic         mem_we;
	logic [11:0]  mem_addr;
	logic [7:0]   mem_wdata, mem_rd;
	logic         fb_we;
	logic [7:0]   fb_addr, fb_wdata, fb_rd;
	logic         v_we;
	logic [3:0]   v_addr;
	logic [7:0]   v_wdata, v_rd;

	logic [11:0]  ex_pc, ex_i, i_cnt;
	logic         ex_vwr, ex_fv, ex_iwr, ex_dtwr, ex_stwr, ex_push, ex_pop, ex_rand;
	logic         ex_draw, ex_wait, ex_unk;
	logic [7:0]   ex_vval;
	c8_pkg::seq_t ex_seq;
	logic [8:0]   sum9;
	logic [15:0]  lfsr_nx;
	logic [3:0]   key_hi;
	logic [SP_W-1:0] sp_inc, sp_dec;
	logic [1:0]   bcd_h;
	logic [7:0]   bcd_r, bcd_t10;
	logic [14:0]  bcd_p;
	logic [3:0]   bcd_t, bcd_o;
	logic [3:0]   digit;
	logic [4:0]   spr_row;
	logic [7:0]   idx1, idx2;
	logic [15:0]  spr_shift;

	assign f_x   = op_q[11:8];
	assign f_y   = op_q[7:4];
	assign f_n   = op_q[3:0];
	assign f_kk  = op_q[7:0];
	assign f_nnn = op_q[11:0];

	assign i_cnt     = 12'(i_q + {4'b0, cnt_q});
	assign sp_inc    = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : SP_W'(sp_q + 1'b1);
	assign sp_dec    = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : SP_W'(sp_q - 1'b1);
	assign sum9      = {1'b0, vx_q} + {1'b0, vy_q};
	assign lfsr_nx   = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? c8_pkg::LFSR_TAPS : 16'h0000);
	assign spr_row   = 5'(vy_q[4:0] + cnt_q[4:0]);
	assign idx1      = {spr_row, vx_q[5:3]};
	assign idx2      = {spr_row, 3'(vx_q[5:3] + 3'd1)};
	assign spr_shift = {mem_rd, 8'h00} >> vx_q[2:0];

	always_comb begin
		key_hi = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (keys_q[k]) begin
				key_hi = 4'(k);
			end
		end
	end

	// decimal digits of vx
	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h = 2'd2;
			bcd_r = 8'(vx_q - 8'd200);
		end else if (vx_q >= 8'd100) begin
			bcd_h = 2'd1;
			bcd_r = 8'(vx_q - 8'd100);
		end else begin
			bcd_h = 2'd0;
			bcd_r = vx_q;
		end
		bcd_p   = 15'(bcd_r[6:0]) * 15'd205;
		bcd_t   = bcd_p[14:11];
		bcd_t10 = {1'b0, bcd_t, 3'b000} + {3'b000, bcd_t, 1'b0};
		bcd_o   = 4'(bcd_r - bcd_t10);
	end

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				digit = {2'b00, bcd_q[9:8]};
			end
			2'd1: begin
				digit = bcd_q[7:4];
			end
			default: begin
				digit = bcd_q[3:0];
			end
		endcase
	end

	// instruction decode and alu
	always_comb begin
		ex_pc   = 12'(pc_q + 12'd2);
		ex_i    = i_q;
		ex_vwr  = 1'b0;
		ex_vval = vx_q;
		ex_fv   = 1'b0;
		ex_iwr  = 1'b0;
		ex_dtwr = 1'b0;
		ex_stwr = 1'b0;
		ex_push = 1'b0;
		ex_pop  = 1'b0;
		ex_rand = 1'b0;
		ex_draw = 1'b0;
		ex_wait = 1'b0;
		ex_unk  = 1'b0;
		ex_seq  = c8_pkg::SEQ_DONE;
		case (op_q[15:12])
			4'h0: begin
				if (op_q == c8_pkg::OPC_CLS) begin
					ex_draw = 1'b1;
					ex_seq  = c8_pkg::SEQ_CLS;
				end else if (op_q == c8_pkg::OPC_RET) begin
					ex_pop = 1'b1;
					ex_pc  = 12'(stack_q[sp_dec] + 12'd2);
				end else begin
					ex_unk = 1'b1;
				end
			end
			4'h1: begin
				ex_pc = f_nnn;
			end
			4'h2: begin
				ex_push = 1'b1;
				ex_pc   = f_nnn;
			end
			4'h3: begin
				if (vx_q == f_kk) ex_pc = 12'(pc_q + 12'd4);
			end
			4'h4: begin
				if (vx_q != f_kk) ex_pc = 12'(pc_q + 12'd4);
			end
			4'h5: begin
				if (vx_q == vy_q) ex_pc = 12'(pc_q + 12'd4);
			end
			4'h6: begin
				ex_vwr  = 1'b1;
				ex_vval = f_kk;
			end
			4'h7: begin
				ex_vwr  = 1'b1;
				ex_vval = 8'(vx_q + f_kk);
			end
			4'h8: begin
				case (f_n)
					4'h0: begin
						ex_vwr  = 1'b1;
						ex_vval = vy_q;
					end
					4'h1: begin
						ex_vwr  = 1'b1;
						ex_vval = vx_q | vy_q;
					end
					4'h2: begin
						ex_vwr  = 1'b1;
						ex_vval = vx_q & vy_q;
					end
					4'h3: begin
						ex_vwr  = 1'b1;
						ex_vval = vx_q ^ vy_q;
					end
					4'h4: begin
						ex_vwr  = 1'b1;
						ex_vval = sum9[7:0];
						ex_fv   = sum9[8];
						ex_seq  = c8_pkg::SEQ_FLAG;
					end
					4'h5: begin
						ex_vwr  = 1'b1;
						ex_vval = 8'(vx_q - vy_q);
						ex_fv   = (vx_q >= vy_q);
						ex_seq  = c8_pkg::SEQ_FLAG;
					end
					4'h7: begin
						ex_vwr  = 1'b1;
						ex_vval = 8'(vy_q - vx_q);
						ex_fv   = (vy_q >= vx_q);
						ex_seq  = c8_pkg::SEQ_FLAG;
					end
					4'h6: begin
						ex_vwr  = 1'b1;
						ex_vval = {1'b0, vx_q[7:1]};
						ex_fv   = vx_q[0];
						ex_seq  = c8_pkg::SEQ_FLAG;
					end
					4'hE: begin
						ex_vwr  = 1'b1;
						ex_vval = {vx_q[6:0], 1'b0};
						ex_fv   = vx_q[7];
						ex_seq  = c8_pkg::SEQ_FLAG;
					end
					default: begin
						ex_unk = 1'b1;
					end
				endcase
			end
			4'h9: begin
				if (vx_q != vy_q) ex_pc = 12'(pc_q + 12'd4);
			end
			4'hA: begin
				ex_iwr = 1'b1;
				ex_i   = f_nnn;
			end
			4'hB: begin
				ex_pc = 12'(f_nnn + {4'b0, vy_q});
			end
			4'hC: begin
				ex_rand = 1'b1;
				ex_vwr  = 1'b1;
				ex_vval = lfsr_nx[7:0] & f_kk;
			end
			4'hD: begin
				ex_draw = 1'b1;
				ex_seq  = (f_n == 4'd0) ? c8_pkg::SEQ_FLAG : c8_pkg::SEQ_SPRITE;
			end
			4'hE: begin
				if (f_kk == c8_pkg::KK_SKP) begin
					if (keys_q[vx_q[3:0]]) ex_pc = 12'(pc_q + 12'd4);
				end else if (f_kk == c8_pkg::KK_SKNP) begin
					if (!keys_q[vx_q[3:0]]) ex_pc = 12'(pc_q + 12'd4);
				end else begin
					ex_unk = 1'b1;
				end
			end
			default: begin
				case (f_kk)
					c8_pkg::KK_LD_DT: begin
						ex_vwr  = 1'b1;
						ex_vval = dt_q;
					end
					c8_pkg::KK_WAIT: begin
						if (keys_q == 16'h0000) begin
							ex_pc   = pc_q;
							ex_wait = 1'b1;
						end else begin
							ex_vwr  = 1'b1;
							ex_vval = {4'b0, key_hi};
						end
					end
					c8_pkg::KK_SET_DT: begin
						ex_dtwr = 1'b1;
					end
					c8_pkg::KK_SET_ST: begin
						ex_stwr = 1'b1;
					end
					c8_pkg::KK_ADD_I: begin
						ex_iwr = 1'b1;
						ex_i   = 12'(i_q + {4'b0, vx_q});
					end
					c8_pkg::KK_FONT: begin
						ex_iwr = 1'b1;
						ex_i   = {6'b0, vx_q[3:0], 2'b00} + {8'b0, vx_q[3:0]};
					end
					c8_pkg::KK_BCD: begin
						ex_seq = c8_pkg::SEQ_BCD;
					end
					c8_pkg::KK_STORE: begin
						ex_seq = c8_pkg::SEQ_STORE;
					end
					c8_pkg::KK_LOAD: begin
						ex_seq = c8_pkg::SEQ_LOAD;
					end
					default: begin
						ex_unk = 1'b1;
					end
				endcase
			end
		endcase
	end

	// status to the controller
	always_comb begin
		stat.init_last = (clr_q == 12'hFFF);
		stat.cmd       = cmd_q;
		stat.seq       = ex_seq;
		case (ex_seq)
			c8_pkg::SEQ_CLS: begin
				stat.cnt_last = (cnt_q == 8'hFF);
			end
			c8_pkg::SEQ_BCD: begin
				stat.cnt_last = (cnt_q == 8'd2);
			end
			c8_pkg::SEQ_STORE, c8_pkg::SEQ_LOAD: begin
				stat.cnt_last = (cnt_q == {4'b0, f_x});
			end
			c8_pkg::SEQ_SPRITE: begin
				stat.cnt_last = (cnt_q == {4'b0, 4'(f_n - 4'd1)});
			end
			default: begin
				stat.cnt_last = 1'b1;
			end
		endcase
	end

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = 12'h000;
		mem_wdata = 8'h00;
		fb_we     = 1'b0;
		fb_addr   = 8'h00;
		fb_wdata  = 8'h00;
		v_we      = 1'b0;
		v_addr    = 4'h0;
		v_wdata   = 8'h00;
		case (op)
			c8_pkg::OP_INIT: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = c8_pkg::font_byte(clr_q);
				fb_we     = (clr_q[11:8] == 4'h0);
				fb_addr   = clr_q[7:0];
				v_we      = (clr_q[11:4] == 8'h00);
				v_addr    = clr_q[3:0];
			end
			c8_pkg::OP_MEM_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = addr_q;
				mem_wdata = wdata_q;
			end
			c8_pkg::OP_FB_READ: begin
				fb_addr = addr_q[7:0];
			end
			c8_pkg::OP_FETCH_HI: begin
				mem_addr = pc_q;
			end
			c8_pkg::OP_FETCH_LO: begin
				mem_addr = 12'(pc_q + 12'd1);
			end
			c8_pkg::OP_READ_X: begin
				v_addr = f_x;
			end
			c8_pkg::OP_READ_Y: begin
				v_addr = (op_q[15:12] == 4'hB) ? 4'h0 : f_y;
			end
			c8_pkg::OP_EXEC: begin
				v_we    = ex_vwr;
				v_addr  = f_x;
				v_wdata = ex_vval;
			end
			c8_pkg::OP_FLAG: begin
				v_we    = 1'b1;
				v_addr  = 4'hF;
				v_wdata = {7'b0, flag_q};
			end
			c8_pkg::OP_CLS: begin
				fb_we   = 1'b1;
				fb_addr = cnt_q;
			end
			c8_pkg::OP_BCD: begin
				mem_we    = 1'b1;
				mem_addr  = i_cnt;
				mem_wdata = {4'b0, digit};
			end
			c8_pkg::OP_ST_RD: begin
				v_addr = cnt_q[3:0];
			end
			c8_pkg::OP_ST_WR: begin
				mem_we    = 1'b1;
				mem_addr  = i_cnt;
				mem_wdata = v_rd;
			end
			c8_pkg::OP_LD_RD, c8_pkg::OP_SPR_MEM: begin
				mem_addr = i_cnt;
			end
			c8_pkg::OP_LD_WR: begin
				v_we    = 1'b1;
				v_addr  = cnt_q[3:0];
				v_wdata = mem_rd;
			end
			c8_pkg::OP_SPR_RD1: begin
				fb_addr = idx1;
			end
			c8_pkg::OP_SPR_WR1: begin
				fb_we    = 1'b1;
				fb_addr  = idx1;
				fb_wdata = fb_rd ^ spr_q[15:8];
			end
			c8_pkg::OP_SPR_RD2: begin
				fb_addr = idx2;
			end
			c8_pkg::OP_SPR_WR2: begin
				fb_we    = 1'b1;
				fb_addr  = idx2;
				fb_wdata = fb_rd ^ spr_q[7:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_BYTES)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rd)
	);

	c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::FB_BYTES)) u_fb (
		.clk  (clk),
		.we   (fb_we),
		.addr (fb_addr),
		.wdata(fb_wdata),
		.rdata(fb_rd)
	);

	c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::NUM_V)) u_vreg (
		.clk  (clk),
		.we   (v_we),
		.addr (v_addr),
		.wdata(v_wdata),
		.rdata(v_rd)
	);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= c8_pkg::PC_START;
			i_q    <= 12'h000;
			sp_q   <= '0;
			dt_q   <= 8'h00;
			st_q   <= 8'h00;
			lfsr_q <= c8_pkg::LFSR_SEED;
			clr_q  <= 12'h000;
			for (int s = 0; s < STACK_DEPTH; s++) begin
				stack_q[s] <= 12'h000;
			end
		end else begin
			case (op)
				c8_pkg::OP_INIT: begin
					clr_q <= 12'(clr_q + 12'd1);
				end
				c8_pkg::OP_TICK: begin
					if (dt_q != 8'h00) dt_q <= 8'(dt_q - 8'd1);
					if (st_q != 8'h00) st_q <= 8'(st_q - 8'd1);
				end
				c8_pkg::OP_EXEC: begin
					pc_q <= ex_pc;
					if (ex_iwr) i_q <= ex_i;
					if (ex_dtwr) dt_q <= vx_q;
					if (ex_stwr) st_q <= vx_q;
					if (ex_rand) lfsr_q <= lfsr_nx;
					if (ex_push) begin
						stack_q[sp_q] <= pc_q;
						sp_q          <= sp_inc;
					end
					if (ex_pop) sp_q <= sp_dec;
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// item and working registers
	always_ff @(posedge clk) begin
		case (op)
			c8_pkg::OP_ACCEPT: begin
				cmd_q   <= c8_pkg::cmd_t'(in_command);
				addr_q  <= in_address;
				wdata_q <= in_write_data;
				keys_q  <= in_key_mask;
				rd_q    <= 8'h00;
				draw_q  <= 1'b0;
				wait_q  <= 1'b0;
				unk_q   <= 1'b0;
			end
			c8_pkg::OP_FB_CAPTURE: begin
				rd_q <= fb_rd;
			end
			c8_pkg::OP_FETCH_LO: begin
				op_q[15:8] <= mem_rd;
			end
			c8_pkg::OP_READ_X: begin
				op_q[7:0] <= mem_rd;
			end
			c8_pkg::OP_READ_Y: begin
				vx_q <= v_rd;
			end
			c8_pkg::OP_CAP_Y: begin
				vy_q <= v_rd;
			end
			c8_pkg::OP_EXEC: begin
				draw_q <= ex_draw;
				wait_q <= ex_wait;
				unk_q  <= ex_unk;
				flag_q <= ex_fv;
				cnt_q  <= 8'h00;
				bcd_q  <= {2'b00, bcd_h, bcd_t, bcd_o};
			end
			c8_pkg::OP_CLS, c8_pkg::OP_BCD, c8_pkg::OP_ST_WR, c8_pkg::OP_LD_WR: begin
				cnt_q <= 8'(cnt_q + 8'd1);
			end
			c8_pkg::OP_SPR_RD1: begin
				spr_q <= spr_shift;
			end
			c8_pkg::OP_SPR_WR1: begin
				flag_q <= flag_q | (|(fb_rd & spr_q[15:8]));
			end
			c8_pkg::OP_SPR_WR2: begin
				flag_q <= flag_q | (|(fb_rd & spr_q[7:0]));
				cnt_q  <= 8'(cnt_q + 8'd1);
			end
			c8_pkg::OP_RESULT: begin
				read_data       <= rd_q;
				draw_changed    <= draw_q;
				waiting_key     <= wait_q;
				sound_on        <= (st_q != 8'h00);
				unknown_op      <= unk_q;
				program_counter <= pc_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end
endmodule

// ===== rtl/c8_ctrl.sv =====
// control state machine of the chip-8 core
module c8_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  c8_pkg::dp_stat_t stat,
	output c8_pkg::dp_op_t   op
);
	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_DISP, ST_TICK, ST_MWR, ST_FRD, ST_FCAP,
		ST_FHI, ST_FLO, ST_RDX, ST_RDY, ST_CAPY, ST_EXEC, ST_FLAG, ST_CLS,
		ST_BCD, ST_STR, ST_STW, ST_LDR, ST_LDW,
		ST_SMEM, ST_SRD1, ST_SWR1, ST_SRD2, ST_SWR2, ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		op      = c8_pkg::OP_NONE;
		case (state_q)
			ST_INIT: begin
				op = c8_pkg::OP_INIT;
				if (stat.init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					op      = c8_pkg::OP_ACCEPT;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.cmd)
					c8_pkg::CMD_EXEC:      state_d = ST_FHI;
					c8_pkg::CMD_TICK:      state_d = ST_TICK;
					c8_pkg::CMD_MEM_WRITE: state_d = ST_MWR;
					default:               state_d = ST_FRD;
				endcase
			end
			ST_TICK: begin
				op      = c8_pkg::OP_TICK;
				state_d = ST_DONE;
			end
			ST_MWR: begin
				op      = c8_pkg::OP_MEM_WRITE;
				state_d = ST_DONE;
			end
			ST_FRD: begin
				op      = c8_pkg::OP_FB_READ;
				state_d = ST_FCAP;
			end
			ST_FCAP: begin
				op      = c8_pkg::OP_FB_CAPTURE;
				state_d = ST_DONE;
			end
			ST_FHI: begin
				op      = c8_pkg::OP_FETCH_HI;
				state_d = ST_FLO;
			end
			ST_FLO: begin
				op      = c8_pkg::OP_FETCH_LO;
				state_d = ST_RDX;
			end
			ST_RDX: begin
				op      = c8_pkg::OP_READ_X;
				state_d = ST_RDY;
			end
			ST_RDY: begin
				op      = c8_pkg::OP_READ_Y;
				state_d = ST_CAPY;
			end
			ST_CAPY: begin
				op      = c8_pkg::OP_CAP_Y;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				op = c8_pkg::OP_EXEC;
				case (stat.seq)
					c8_pkg::SEQ_FLAG:   state_d = ST_FLAG;
					c8_pkg::SEQ_CLS:    state_d = ST_CLS;
					c8_pkg::SEQ_BCD:    state_d = ST_BCD;
					c8_pkg::SEQ_STORE:  state_d = ST_STR;
					c8_pkg::SEQ_LOAD:   state_d = ST_LDR;
					c8_pkg::SEQ_SPRITE: state_d = ST_SMEM;
					default:            state_d = ST_DONE;
				endcase
			end
			ST_FLAG: begin
				op      = c8_pkg::OP_FLAG;
				state_d = ST_DONE;
			end
			ST_CLS: begin
				op = c8_pkg::OP_CLS;
				if (stat.cnt_last) state_d = ST_DONE;
			end
			ST_BCD: begin
				op = c8_pkg::OP_BCD;
				if (stat.cnt_last) state_d = ST_DONE;
			end
			ST_STR: begin
				op      = c8_pkg::OP_ST_RD;
				state_d = ST_STW;
			end
			ST_STW: begin
				op      = c8_pkg::OP_ST_WR;
				state_d = stat.cnt_last ? ST_DONE : ST_STR;
			end
			ST_LDR: begin
				op      = c8_pkg::OP_LD_RD;
				state_d = ST_LDW;
			end
			ST_LDW: begin
				op      = c8_pkg::OP_LD_WR;
				state_d = stat.cnt_last ? ST_DONE : ST_LDR;
			end
			ST_SMEM: begin
				op      = c8_pkg::OP_SPR_MEM;
				state_d = ST_SRD1;
			end
			ST_SRD1: begin
				op      = c8_pkg::OP_SPR_RD1;
				state_d = ST_SWR1;
			end
			ST_SWR1: begin
				op      = c8_pkg::OP_SPR_WR1;
				state_d = ST_SRD2;
			end
			ST_SRD2: begin
				op      = c8_pkg::OP_SPR_RD2;
				state_d = ST_SWR2;
			end
			ST_SWR2: begin
				op      = c8_pkg::OP_SPR_WR2;
				state_d = stat.cnt_last ? ST_FLAG : ST_SMEM;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					op      = c8_pkg::OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == c8_pkg::OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/chip8_interpreter_core.sv =====
// chip-8 core top level: controller, datapath and checks
// usage:
// - in_ch takes one item per command: execute one instruction with a key mask,
//   tick the timers, write a memory byte (rom loading) or read eight pixels
// - out_ch returns exactly one result item per input item, in order
// - an instruction is fetched, its operands read and then executed; a
//   flag-setting alu op then writes vf
// - screen clear writes one framebuffer byte at a time, and sprite draw
//   reads and writes two framebuffer bytes per row through the single port
// - block store or load moves one register at a time; bcd store writes one
//   digit at a time
// one item is in work at a time; a new item is taken while the previous
// result still waits in the output register
// after reset the core runs a pass over all of memory that writes the font
// and zeros into memory and clears the framebuffer and registers; no item is
// taken then; when the receiver stalls, the result holds and the core stops
// before its next result until the output register is free
module chip8_interpreter_core #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	c8_in_if.sink   in_ch,
	c8_out_if.source out_ch
);
	c8_pkg::dp_op_t   dp_op;
	c8_pkg::dp_stat_t dp_stat;

	c8_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.stat     (dp_stat),
		.op       (dp_op)
	);

	c8_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (dp_op),
		.in_command     (in_ch.command),
		.in_address     (in_ch.address),
		.in_write_data  (in_ch.write_data),
		.in_key_mask    (in_ch.key_mask),
		.stat           (dp_stat),
		.read_data      (out_ch.read_data),
		.draw_changed   (out_ch.draw_changed),
		.waiting_key    (out_ch.waiting_key),
		.sound_on       (out_ch.sound_on),
		.unknown_op     (out_ch.unknown_op),
		.program_counter(out_ch.program_counter)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item taken while one is in work");

	a_exec_after_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_op == c8_pkg::OP_EXEC) |-> ($past(dp_op) == c8_pkg::OP_CAP_Y))
		else $error("execute without operand fetch");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $onehot0({out_ch.draw_changed, out_ch.waiting_key, out_ch.unknown_op}))
		else $error("conflicting result flags");
`endif
endmodule

// ===== dv/chip8_interpreter_core_tb.sv =====
// testbench of the chip-8 core: directed table and random programs checked against a predictor
`timescale 1ns / 100ps

module chip8_interpreter_core_tb;

	typedef enum logic [3:0] {
		GRP_SYS, GRP_JP, GRP_CALL, GRP_SE, GRP_SNE, GRP_SER, GRP_LD, GRP_ADD,
		GRP_ALU, GRP_SNER, GRP_LDI, GRP_JPV, GRP_RND, GRP_DRW, GRP_KEY, GRP_MISC
	} op_group_t;

	typedef enum logic [3:0] {
		ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3, ALU_ADD = 4'h4,
		ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7, ALU_SHL = 4'hE
	} alu_op_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        draw_changed;
		logic        waiting_key;
		logic        sound_on;
		logic        unknown_op;
		logic [11:0] program_counter;
	} core_result_t;

	typedef struct {
		c8_pkg::cmd_t command;
		logic [11:0]  address;
		logic [7:0]   write_data;
		logic [15:0]  key_mask;
		logic         typed;
		core_result_t result;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1650;

	logic clk;
	logic arst_n;
	c8_in_if  in_ch();
	c8_out_if out_ch();

	chip8_interpreter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor state
	logic [7:0]  mem_img [c8_pkg::MEM_BYTES];
	logic [7:0]  v_reg [16];
	logic [11:0] i_reg;
	logic [11:0] pc_reg;
	logic [3:0]  sp_reg;
	logic [11:0] stack_img [16];
	logic [7:0]  delay_reg;
	logic [7:0]  sound_reg;
	logic        pixel_img [2048];
	logic [15:0] lfsr_reg;

	core_result_t pending_results[$];
	int fail_count;
	int idle_cycles;
	int burst_left;
	int stall_left;
	logic stall_state;
	logic stall_enable;

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic void reset_model();
		for (int a = 0; a < c8_pkg::MEM_BYTES; a++)
			mem_img[a] = (a < c8_pkg::FONT_BYTES) ? c8_pkg::FONT_ROM[a] : 8'h00;
		for (int r = 0; r < 16; r++) begin
			v_reg[r] = 8'h00;
			stack_img[r] = 12'h000;
		end
		for (int p = 0; p < 2048; p++)
			pixel_img[p] = 1'b0;
		i_reg = 12'h000;
		pc_reg = c8_pkg::PC_START;
		sp_reg = 4'h0;
		delay_reg = 8'h00;
		sound_reg = 8'h00;
		lfsr_reg = c8_pkg::LFSR_SEED;
	endfunction

	function automatic core_result_t predict_core(input c8_pkg::cmd_t command,
			input logic [11:0] address, input logic [7:0] write_data,
			input logic [15:0] key_mask);
		core_result_t res;
		logic [15:0] op;
		logic [3:0]  x, y, n;
		logic [7:0]  kk, vx, vy, bits;
		logic [11:0] nnn, next;
		logic [8:0]  sum;
		logic        hit;
		int          p;
		res = '0;
		case (command)
			c8_pkg::CMD_EXEC: begin
				op = {mem_img[pc_reg], mem_img[12'(pc_reg + 12'd1)]};
				x = op[11:8];
				y = op[7:4];
				n = op[3:0];
				kk = op[7:0];
				nnn = op[11:0];
				vx = v_reg[x];
				vy = v_reg[y];
				next = 12'(pc_reg + 12'd2);
				case (op_group_t'(op[15:12]))
					GRP_SYS: begin
						if (op == c8_pkg::OPC_CLS) begin
							for (int q = 0; q < 2048; q++)
								pixel_img[q] = 1'b0;
							res.draw_changed = 1'b1;
						end else if (op == c8_pkg::OPC_RET) begin
							sp_reg = 4'(sp_reg - 4'd1);
							next = 12'(stack_img[sp_reg] + 12'd2);
						end else begin
							res.unknown_op = 1'b1;
						end
					end
					GRP_JP: next = nnn;
					GRP_CALL: begin
						stack_img[sp_reg] = pc_reg;
						sp_reg = 4'(sp_reg + 4'd1);
						next = nnn;
					end
					GRP_SE: if (vx == kk) next += 12'd2;
					GRP_SNE: if (vx != kk) next += 12'd2;
					GRP_SER: if (vx == vy) next += 12'd2;
					GRP_LD: v_reg[x] = kk;
					GRP_ADD: v_reg[x] = 8'(vx + kk);
					GRP_ALU: begin
						case (n)
							ALU_MOV: v_reg[x] = vy;
							ALU_OR: v_reg[x] = vx | vy;
							ALU_AND: v_reg[x] = vx & vy;
							ALU_XOR: v_reg[x] = vx ^ vy;
							ALU_ADD: begin
								sum = {1'b0, vx} + {1'b0, vy};
								v_reg[x] = sum[7:0];
								v_reg[15] = {7'd0, sum[8]};
							end
							ALU_SUB: begin
								v_reg[x] = 8'(vx - vy);
								v_reg[15] = {7'd0, vx >= vy};
							end
							ALU_SUBN: begin
								v_reg[x] = 8'(vy - vx);
								v_reg[15] = {7'd0, vy >= vx};
							end
							ALU_SHR: begin
								v_reg[x] = {1'b0, vx[7:1]};
								v_reg[15] = {7'd0, vx[0]};
							end
							ALU_SHL: begin
								v_reg[x] = {vx[6:0], 1'b0};
								v_reg[15] = {7'd0, vx[7]};
							end
							default: res.unknown_op = 1'b1;
						endcase
					end
					GRP_SNER: if (vx != vy) next += 12'd2;
					GRP_LDI: i_reg = nnn;
					GRP_JPV: next = 12'(nnn + {4'b0, v_reg[0]});
					GRP_RND: begin
						lfsr_reg = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ c8_pkg::LFSR_TAPS)
							: (lfsr_reg >> 1);
						v_reg[x] = lfsr_reg[7:0] & kk;
					end
					GRP_DRW: begin
						hit = 1'b0;
						for (int r = 0; r < n; r++) begin
							bits = mem_img[12'(i_reg + 12'(r))];
							for (int c = 0; c < 8; c++) begin
								if (bits[7 - c]) begin
									p = ((vx + c) % 64) + ((vy + r) % 32) * 64;
									if (pixel_img[p]) hit = 1'b1;
									pixel_img[p] = ~pixel_img[p];
								end
							end
						end
						v_reg[15] = {7'd0, hit};
						res.draw_changed = 1'b1;
					end
					GRP_KEY: begin
						if (kk == c8_pkg::KK_SKP) begin
							if (key_mask[vx[3:0]]) next += 12'd2;
						end else if (kk == c8_pkg::KK_SKNP) begin
							if (!key_mask[vx[3:0]]) next += 12'd2;
						end else begin
							res.unknown_op = 1'b1;
						end
					end
					default: begin
						case (kk)
							c8_pkg::KK_LD_DT: v_reg[x] = delay_reg;
							c8_pkg::KK_WAIT: begin
								if (key_mask == 16'h0000) begin
									next = pc_reg;
									res.waiting_key = 1'b1;
								end else begin
									for (int k = 0; k < 16; k++)
										if (key_mask[k]) v_reg[x] = 8'(k);
								end
							end
							c8_pkg::KK_SET_DT: delay_reg = vx;
							c8_pkg::KK_SET_ST: sound_reg = vx;
							c8_pkg::KK_ADD_I: i_reg = 12'(i_reg + {4'b0, vx});
							c8_pkg::KK_FONT: i_reg = 12'({8'b0, vx[3:0]} * 12'd5);
							c8_pkg::KK_BCD: begin
								mem_img[i_reg] = 8'(vx / 100);
								mem_img[12'(i_reg + 12'd1)] = 8'((vx / 10) % 10);
								mem_img[12'(i_reg + 12'd2)] = 8'(vx % 10);
							end
							c8_pkg::KK_STORE:
								for (int k = 0; k <= x; k++)
									mem_img[12'(i_reg + 12'(k))] = v_reg[k];
							c8_pkg::KK_LOAD:
								for (int k = 0; k <= x; k++)
									v_reg[k] = mem_img[12'(i_reg + 12'(k))];
							default: res.unknown_op = 1'b1;
						endcase
					end
				endcase
				pc_reg = next;
			end
			c8_pkg::CMD_TICK: begin
				if (delay_reg != 0) delay_reg--;
				if (sound_reg != 0) sound_reg--;
			end
			c8_pkg::CMD_MEM_WRITE: mem_img[address] = write_data;
			default:
				for (int k = 0; k < 8; k++)
					res.read_data[7 - k] = pixel_img[address[7:0] * 8 + k];
		endcase
		res.sound_on = (sound_reg != 0);
		res.program_counter = pc_reg;
		return res;
	endfunction

	task automatic send_item(input c8_pkg::cmd_t command, input logic [11:0] address,
			input logic [7:0] write_data, input logic [15:0] key_mask,
			input logic typed, input core_result_t typed_result);
		core_result_t res;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		in_ch.valid = 1'b1;
		in_ch.command = command;
		in_ch.address = address;
		in_ch.write_data = write_data;
		in_ch.key_mask = key_mask;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		res = predict_core(command, address, write_data, key_mask);
		pending_results.push_back(typed ? typed_result : res);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic logic [15:0] random_opcode();
		logic [15:0] op;
		op = 16'($urandom_range(0, 65535));
		case (op_group_t'(op[15:12]))
			GRP_SYS: begin
				case ($urandom_range(0, 9))
					0: op = c8_pkg::OPC_CLS;
					1, 2, 3, 4: op = c8_pkg::OPC_RET;
					default: ;
				endcase
			end
			GRP_DRW: if ($urandom_range(0, 4) != 0) op[3:0] = 4'($urandom_range(0, 5));
			GRP_KEY: begin
				case ($urandom_range(0, 4))
					0, 1: op[7:0] = c8_pkg::KK_SKP;
					2, 3: op[7:0] = c8_pkg::KK_SKNP;
					default: ;
				endcase
			end
			GRP_MISC: begin
				case ($urandom_range(0, 10))
					0: op[7:0] = c8_pkg::KK_LD_DT;
					1: op[7:0] = c8_pkg::KK_WAIT;
					2: op[7:0] = c8_pkg::KK_SET_DT;
					3: op[7:0] = c8_pkg::KK_SET_ST;
					4: op[7:0] = c8_pkg::KK_ADD_I;
					5: op[7:0] = c8_pkg::KK_FONT;
					6: op[7:0] = c8_pkg::KK_BCD;
					7: op[7:0] = c8_pkg::KK_STORE;
					8: op[7:0] = c8_pkg::KK_LOAD;
					default: ;
				endcase
			end
			default: ;
		endcase
		return op;
	endfunction

	function automatic logic [15:0] random_keys();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001 << $urandom_range(0, 15);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_state = ~stall_state;
			stall_left = stall_state ? $urandom_range(1, 20) : $urandom_range(1, 6);
		end
		stall_left--;
		out_ch.ready <= stall_enable ? stall_state : 1'b1;
	end

	always @(posedge clk) begin
		core_result_t want;
		if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.read_data !== want.read_data)
					report_mismatch("read_data", out_ch.read_data, want.read_data);
				if (out_ch.draw_changed !== want.draw_changed)
					report_mismatch("draw_changed", out_ch.draw_changed, want.draw_changed);
				if (out_ch.waiting_key !== want.waiting_key)
					report_mismatch("waiting_key", out_ch.waiting_key, want.waiting_key);
				if (out_ch.sound_on !== want.sound_on)
					report_mismatch("sound_on", out_ch.sound_on, want.sound_on);
				if (out_ch.unknown_op !== want.unknown_op)
					report_mismatch("unknown_op", out_ch.unknown_op, want.unknown_op);
				if (out_ch.program_counter !== want.program_counter)
					report_mismatch("program_counter", out_ch.program_counter,
						want.program_counter);
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		logic [15:0] op;
		int choice;
		logic drained;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = c8_pkg::CMD_EXEC;
		in_ch.address = '0;
		in_ch.write_data = '0;
		in_ch.key_mask = '0;
		out_ch.ready = 1'b1;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		stall_left = 0;
		stall_state = 1'b0;
		stall_enable = 1'b0;
		drained = 1'b0;
		reset_model();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{c8_pkg::CMD_FB_READ, 12'h000, 8'h00, 16'h0000, 1'b1,
				'{8'h00, 0, 0, 0, 0, 12'h200}},
			'{c8_pkg::CMD_TICK, 12'h000, 8'h00, 16'h0000, 1'b1,
				'{8'h00, 0, 0, 0, 0, 12'h200}},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b1,
				'{8'h00, 0, 0, 0, 1, 12'h202}},
			'{c8_pkg::CMD_MEM_WRITE, 12'h202, 8'h60, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h203, 8'hFF, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h204, 8'h80, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h205, 8'h04, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h206, 8'hD0, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h207, 8'h05, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_FB_READ, 12'h0FF, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h208, 8'hF0, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h209, 8'h0A, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h8000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h20A, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'h20B, 8'hE0, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_MEM_WRITE, 12'hFFF, 8'hFF, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_FB_READ, 12'hFFF, 8'h00, 16'h0000, 1'b0, '0},
			'{c8_pkg::CMD_EXEC, 12'h000, 8'h00, 16'hFFFF, 1'b0, '0}
		};
		foreach (rows[r])
			send_item(rows[r].command, rows[r].address, rows[r].write_data, rows[r].key_mask,
				rows[r].typed, rows[r].result);

		for (int n = 0; n < RANDOM_ITEMS; ) begin
			if (n > RANDOM_ITEMS / 4) stall_enable = 1'b1;
			if (!drained && n >= RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				while (pending_results.size() != 0) @(negedge clk);
			end
			choice = $urandom_range(0, 19);
			if (choice < 16) begin
				op = random_opcode();
				send_item(c8_pkg::CMD_MEM_WRITE, pc_reg, op[15:8], random_keys(), 1'b0, '0);
				send_item(c8_pkg::CMD_MEM_WRITE, 12'(pc_reg + 12'd1), op[7:0], random_keys(),
					1'b0, '0);
				send_item(c8_pkg::CMD_EXEC, 12'($urandom_range(0, 4095)),
					8'($urandom_range(0, 255)), random_keys(), 1'b0, '0);
				n += 3;
			end else begin
				send_item(c8_pkg::cmd_t'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
					8'($urandom_range(0, 255)), random_keys(), 1'b0, '0);
				n++;
			end
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== chip8_interpreter_core.f =====
rtl/c8_pkg.sv
rtl/c8_in_if.sv
rtl/c8_out_if.sv
rtl/c8_ram.sv
rtl/c8_dpath.sv
rtl/c8_ctrl.sv
rtl/chip8_interpreter_core.sv
dv/chip8_interpreter_core_tb.sv
